@@ rtl/noga_pkg.sv @@
// ----------------------------------------------------------------------------
// noga_pkg
// Shared types and constants of the nearest-observation grid accumulator.
// ----------------------------------------------------------------------------
package noga_pkg;

    localparam int GRID_CELLS = 4096;
    localparam int CELL_W     = $clog2(GRID_CELLS);
    localparam int VALUE_W    = 32;
    localparam int DIST_W     = 24;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_OBS_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_DATA_CODE = 2'd2;

    localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST  = {DIST_W{1'b1}};
    localparam logic [VALUE_W-1:0] BAD_OBS_CODE_RST  = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] BAD_DATA_CODE_RST = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic                occupied;
        logic [DIST_W-1:0]   best_dist;
        logic [VALUE_W-1:0]  value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ rtl/nearest_obs_grid_accumulator.sv @@
// ----------------------------------------------------------------------------
// nearest_obs_grid_accumulator
// Keeps the nearest usable observation per grid cell; clears, adds, reads or does nothing (NOP).
// ----------------------------------------------------------------------------
// The item is captured and its cell read at the input transfer; the result
// is registered in ST_UPDATE once the output is free. Input is stalled while
// an item is in flight, set by the read-modify-write of the single cell memory
// (write-back in ST_UPDATE). Reset: synchronous, active low; afterwards a sweep
// clears all GRID_CELLS (4096) cells with input stalled; configuration is taken always.
// ----------------------------------------------------------------------------
module nearest_obs_grid_accumulator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [noga_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [noga_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [noga_pkg::MODE_W-1:0]      i_mode,
    input  logic [noga_pkg::CELL_W-1:0]      i_cell_index,
    input  logic signed [noga_pkg::VALUE_W-1:0] i_obs_sample,
    input  logic [noga_pkg::DIST_W-1:0]      i_distance,
    input  logic                             i_distance_invalid,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [noga_pkg::CELL_W-1:0]      o_result_cell,
    output logic signed [noga_pkg::VALUE_W-1:0] o_result_value,
    output logic                             o_result_filled,
    output logic                             o_result_updated
);

    import noga_pkg::*;

    t_state               r_state, n_state;
    logic [CELL_W-1:0]    r_sweep_addr;
    logic [DIST_W-1:0]    r_max_distance;
    logic [VALUE_W-1:0]   r_bad_obs_code;
    logic [VALUE_W-1:0]   r_bad_data_code;

    t_mode                r_mode;
    logic [CELL_W-1:0]    r_cell;
    logic [VALUE_W-1:0]   r_obs_sample;
    logic [DIST_W-1:0]    r_distance;
    logic                 r_distance_invalid;

    logic                 r_out_valid;
    logic [CELL_W-1:0]    r_out_cell;
    logic [VALUE_W-1:0]   r_out_value;
    logic                 r_out_filled;
    logic                 r_out_updated;

    logic                 in_xfer;
    logic                 out_free;
    logic                 load_out;
    logic                 ram_we;
    logic [CELL_W-1:0]    ram_waddr;
    logic [CELL_W-1:0]    ram_raddr;
    t_entry               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_entry               cur;
    logic                 skip;
    logic                 usable;
    logic                 upd;
    logic [VALUE_W-1:0]   res_value;
    logic                 res_filled;
    logic                 res_updated;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_out   = (r_state == ST_UPDATE) && out_free;
    assign ram_raddr  = (r_state == ST_IDLE) ? i_cell_index : r_cell;
    assign cur        = t_entry'(ram_rdata);

    noga_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GRID_CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        skip   = (r_obs_sample == r_bad_obs_code) || r_distance_invalid ||
                 (r_distance > r_max_distance);
        usable = cur.occupied && (cur.best_dist <= r_max_distance);
        upd    = !skip && (!cur.occupied || (r_distance < cur.best_dist));

        res_value   = '0;
        res_filled  = 1'b0;
        res_updated = 1'b0;
        case (r_mode)
            MODE_CLEAR: begin
            end
            MODE_ADD: begin
                res_updated = upd;
                res_filled  = upd ? 1'b1 : usable;
            end
            MODE_READ: begin
                res_filled = usable;
                res_value  = usable ? cur.value : r_bad_data_code;
            end
            MODE_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_cell;
        ram_wdata = '0;
        case (r_state)
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep_addr;
                if (r_sweep_addr == CELL_W'(GRID_CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                    if (r_mode == MODE_CLEAR) begin
                        ram_we = 1'b1;
                    end else if (r_mode == MODE_ADD && upd) begin
                        ram_we         = 1'b1;
                        ram_wdata.occupied  = 1'b1;
                        ram_wdata.best_dist = r_distance;
                        ram_wdata.value     = r_obs_sample;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance  <= MAX_DISTANCE_RST;
            r_bad_obs_code  <= BAD_OBS_CODE_RST;
            r_bad_data_code <= BAD_DATA_CODE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAX_DISTANCE:  r_max_distance  <= i_cfg_wdata[DIST_W-1:0];
                CFG_BAD_OBS_CODE:  r_bad_obs_code  <= i_cfg_wdata[VALUE_W-1:0];
                CFG_BAD_DATA_CODE: r_bad_data_code <= i_cfg_wdata[VALUE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // capture the item at transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode             <= t_mode'(i_mode);
            r_cell             <= i_cell_index;
            r_obs_sample       <= i_obs_sample;
            r_distance         <= i_distance;
            r_distance_invalid <= i_distance_invalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_cell    <= r_cell;
            r_out_value   <= res_value;
            r_out_filled  <= res_filled;
            r_out_updated <= res_updated;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_cell    = r_out_cell;
    assign o_result_value   = r_out_value;
    assign o_result_filled  = r_out_filled;
    assign o_result_updated = r_out_updated;

endmodule

@@ rtl/noga_ram.sv @@
// ----------------------------------------------------------------------------
// noga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module noga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/noga_checker.sv @@
// ----------------------------------------------------------------------------
// noga_checker
// Port-level checks of the grid accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module noga_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic [noga_pkg::CELL_W-1:0]      o_result_cell,
    input  logic signed [noga_pkg::VALUE_W-1:0] o_result_value,
    input  logic                             o_result_filled,
    input  logic                             o_result_updated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_result_cell) && $stable(o_result_value) &&
            $stable(o_result_filled) && $stable(o_result_updated))
        else $error("stalled result changed");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer while an item is in flight");

    a_upd_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_updated |-> o_result_filled)
        else $error("updated cell not reported filled");

    a_upd_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_updated |-> o_result_value == '0)
        else $error("add result carries a nonzero value");

endmodule

bind nearest_obs_grid_accumulator noga_checker u_noga_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_result_cell    (o_result_cell),
    .o_result_value   (o_result_value),
    .o_result_filled  (o_result_filled),
    .o_result_updated (o_result_updated)
);
